// ===== hdl/hsv_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hsv_pkg
// shared types, constants and gamma tables for the hsv to rgb duty converter
// ----------------------------------------------------------------------------
package hsv_pkg;

  // field widths and limits
  localparam int HUE_W          = 9;
  localparam int SAT_W          = 7;
  localparam int VAL_W          = 7;
  localparam int REM_W          = 6;
  localparam int CHAN_W         = 8;
  localparam int DUTY_W         = 16;
  localparam int PWM_BITS_W     = 5;

  localparam int HUE_WRAP       = 360;
  localparam int HUE_SECTOR_DEG = 60;
  localparam int PCT_MAX        = 100;
  localparam int CHAN_MAX       = 255;
  localparam int QT_SCALE       = 6000;

  localparam int MAX_PWM_BITS   = 16;
  localparam int PWM_BITS_RESET = 8;
  localparam int GAMMA_FRAC_BITS = 16;
  localparam int ROM_W          = GAMMA_FRAC_BITS + 1;
  localparam int ROM_DEPTH      = 256;

  // gamma exponents as fractions
  localparam int RG_EXP_NUM     = 14;
  localparam int RG_EXP_DEN     = 5;
  localparam int B_EXP_NUM      = 7;
  localparam int B_EXP_DEN      = 2;

  // queue between front and back
  localparam int FIFO_DEPTH     = 4;
  localparam int FIFO_PTR_W     = $clog2(FIFO_DEPTH);
  localparam int FIFO_CNT_W     = $clog2(FIFO_DEPTH + 1);

  // intermediate widths
  localparam int V255_W         = 15;  // 255 * v
  localparam int SR_W           = 13;  // s * rem, up to 6000
  localparam int NF_W           = 15;  // numerator of full
  localparam int NP_W           = 22;  // numerator of p
  localparam int NQT_W          = 28;  // numerator of q and t
  localparam int M_W            = 9;   // reciprocal width

  // constant division: estimate by reciprocal, then one correction step
  localparam int D_FULL         = 100;
  localparam int K_FULL         = 15;
  localparam int M_FULL         = (1 << K_FULL) / D_FULL;
  localparam int D_P            = 10000;
  localparam int K_P            = 22;
  localparam int M_P            = (1 << K_P) / D_P;
  localparam int D_QT           = 600000;
  localparam int K_QT           = 28;
  localparam int M_QT           = (1 << K_QT) / D_QT;

  typedef struct packed {
    logic [HUE_W-1:0] hue;
    logic [SAT_W-1:0] saturation;
    logic [VAL_W-1:0] brightness;
  } in_item_t;

  typedef struct packed {
    logic [DUTY_W-1:0] red_duty;
    logic [DUTY_W-1:0] green_duty;
    logic [DUTY_W-1:0] blue_duty;
  } out_item_t;

  typedef enum logic [2:0] {
    SEC_R_TO_Y = 3'd0,
    SEC_Y_TO_G = 3'd1,
    SEC_G_TO_C = 3'd2,
    SEC_C_TO_B = 3'd3,
    SEC_B_TO_M = 3'd4,
    SEC_M_TO_R = 3'd5
  } sector_t;

  // classified color as queued between front and back
  typedef struct packed {
    logic             sat_zero;
    sector_t          sector;
    logic [REM_W-1:0] rem;
    logic [SAT_W-1:0] sat;
    logic [VAL_W-1:0] val;
  } hsv_cls_t;

  typedef struct packed {
    logic full;
    logic empty;
  } fifo_stat_t;

  // gamma tables, built exactly at elaboration
  localparam int BN_W = RG_EXP_NUM * CHAN_W + RG_EXP_DEN * GAMMA_FRAC_BITS + 8;

  typedef logic [ROM_W-1:0] gamma_rom_t [ROM_DEPTH];

  // largest y with y^d * 255^n <= x^n * 2^(d*frac_bits)
  function automatic logic [ROM_W-1:0] gamma_frac(input int unsigned x,
                                                  input int unsigned n,
                                                  input int unsigned d);
    logic [BN_W-1:0] rhs;
    logic [BN_W-1:0] lhs;
    logic [BN_W-1:0] xw;
    logic [BN_W-1:0] mw;
    int unsigned     lo;
    int unsigned     hi;
    int unsigned     mid;
    rhs = BN_W'(1);
    xw  = BN_W'(x);
    for (int k = 0; k < n; k++) begin
      rhs = rhs * xw;
    end
    rhs = rhs << (d * GAMMA_FRAC_BITS);
    lo  = 0;
    hi  = 1 << GAMMA_FRAC_BITS;
    for (int it = 0; it <= GAMMA_FRAC_BITS + 1; it++) begin
      if (lo < hi) begin
        mid = lo + ((hi - lo + 1) >> 1);
        mw  = BN_W'(mid);
        lhs = BN_W'(1);
        for (int k = 0; k < d; k++) begin
          lhs = lhs * mw;
        end
        for (int k = 0; k < n; k++) begin
          lhs = lhs * BN_W'(CHAN_MAX);
        end
        if (lhs <= rhs) begin
          lo = mid;
        end else begin
          hi = mid - 1;
        end
      end
    end
    return ROM_W'(lo);
  endfunction

  function automatic gamma_rom_t build_rom(input int unsigned n, input int unsigned d);
    gamma_rom_t rom;
    for (int x = 0; x < ROM_DEPTH; x++) begin
      rom[x] = gamma_frac(x, n, d);
    end
    return rom;
  endfunction

  localparam gamma_rom_t GAMMA_RG = build_rom(RG_EXP_NUM, RG_EXP_DEN);
  localparam gamma_rom_t GAMMA_B  = build_rom(B_EXP_NUM, B_EXP_DEN);

endpackage

// ===== hdl/hsv_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hsv_front
// accepts colors, clamps the fields and splits hue into sector and remainder
// ----------------------------------------------------------------------------
module hsv_front import hsv_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  in_item_t   in_data,
  input  fifo_stat_t stat,
  output logic       push,
  output hsv_cls_t   push_data
);

  logic             hold_v_r;
  logic             hold_v_nxt;
  hsv_cls_t         hold_r;
  hsv_cls_t         hold_nxt;
  logic             accept;
  logic [HUE_W-1:0] hue_w;
  logic [HUE_W-1:0] base;
  sector_t          sec;

  assign in_stall  = hold_v_r && stat.full;
  assign accept    = in_valid && !in_stall;
  assign push      = hold_v_r && !stat.full;
  assign push_data = hold_r;

  always_comb begin
    hue_w = (in_data.hue >= HUE_W'(HUE_WRAP)) ? in_data.hue - HUE_W'(HUE_WRAP)
                                               : in_data.hue;
    if (hue_w >= HUE_W'(5 * HUE_SECTOR_DEG)) begin
      sec  = SEC_M_TO_R;
      base = HUE_W'(5 * HUE_SECTOR_DEG);
    end else if (hue_w >= HUE_W'(4 * HUE_SECTOR_DEG)) begin
      sec  = SEC_B_TO_M;
      base = HUE_W'(4 * HUE_SECTOR_DEG);
    end else if (hue_w >= HUE_W'(3 * HUE_SECTOR_DEG)) begin
      sec  = SEC_C_TO_B;
      base = HUE_W'(3 * HUE_SECTOR_DEG);
    end else if (hue_w >= HUE_W'(2 * HUE_SECTOR_DEG)) begin
      sec  = SEC_G_TO_C;
      base = HUE_W'(2 * HUE_SECTOR_DEG);
    end else if (hue_w >= HUE_W'(HUE_SECTOR_DEG)) begin
      sec  = SEC_Y_TO_G;
      base = HUE_W'(HUE_SECTOR_DEG);
    end else begin
      sec  = SEC_R_TO_Y;
      base = '0;
    end

    hold_nxt.sat_zero = (in_data.saturation == '0);
    hold_nxt.sector   = sec;
    hold_nxt.rem      = REM_W'(hue_w - base);
    hold_nxt.sat      = (in_data.saturation > SAT_W'(PCT_MAX)) ? SAT_W'(PCT_MAX)
                                                                : in_data.saturation;
    hold_nxt.val      = (in_data.brightness > VAL_W'(PCT_MAX)) ? VAL_W'(PCT_MAX)
                                                                : in_data.brightness;

    hold_v_nxt = hold_v_r;
    if (accept) begin
      hold_v_nxt = 1'b1;
    end else if (push) begin
      hold_v_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hold_v_r <= 1'b0;
    end else begin
      hold_v_r <= hold_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      hold_r <= hold_nxt;
    end
  end

endmodule

// ===== hdl/hsv_fifo.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hsv_fifo
// short queue of classified colors between front and back
// ----------------------------------------------------------------------------
module hsv_fifo import hsv_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       push,
  input  hsv_cls_t   push_data,
  input  logic       pop,
  output hsv_cls_t   pop_data,
  output fifo_stat_t stat
);

  hsv_cls_t              mem_r [FIFO_DEPTH];
  logic [FIFO_PTR_W-1:0] wr_ptr_r;
  logic [FIFO_PTR_W-1:0] wr_ptr_nxt;
  logic [FIFO_PTR_W-1:0] rd_ptr_r;
  logic [FIFO_PTR_W-1:0] rd_ptr_nxt;
  logic [FIFO_CNT_W-1:0] count_r;
  logic [FIFO_CNT_W-1:0] count_nxt;

  assign stat.full  = (count_r == FIFO_CNT_W'(FIFO_DEPTH));
  assign stat.empty = (count_r == '0);
  assign pop_data   = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r;
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

// ===== hdl/hsv_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hsv_back
// seven-stage pipeline: channel values, gamma lookup and duty scaling
// ----------------------------------------------------------------------------
module hsv_back import hsv_pkg::*; (
  input  logic                    clk,
  input  logic                    rst_n,
  input  fifo_stat_t              stat,
  output logic                    pop,
  input  hsv_cls_t                pop_data,
  input  logic [MAX_PWM_BITS-1:0] scale,
  output logic                    out_valid,
  input  logic                    out_stall,
  output out_item_t               out_data
);

  localparam int PROD_W = ROM_W + DUTY_W;

  logic en;

  // stage 1: 255*v and saturation products
  logic              s1_v_r;
  logic [V255_W-1:0] s1_v255_r, s1_v255_nxt;
  logic [SAT_W-1:0]  s1_ds_r, s1_ds_nxt;
  logic [SR_W-1:0]   s1_srq_r, s1_srq_nxt;
  logic [SR_W-1:0]   s1_srt_r, s1_srt_nxt;
  sector_t           s1_sec_r;
  logic              s1_sz_r;

  // stage 2: numerators
  logic              s2_v_r;
  logic [NF_W-1:0]   s2_nf_r, s2_nf_nxt;
  logic [NP_W-1:0]   s2_np_r, s2_np_nxt;
  logic [NQT_W-1:0]  s2_nq_r, s2_nq_nxt;
  logic [NQT_W-1:0]  s2_nt_r, s2_nt_nxt;
  sector_t           s2_sec_r;
  logic              s2_sz_r;

  // stage 3: quotient estimates
  logic              s3_v_r;
  logic [NF_W-1:0]   s3_nf_r;
  logic [NP_W-1:0]   s3_np_r;
  logic [NQT_W-1:0]  s3_nq_r, s3_nt_r;
  logic [CHAN_W-1:0] s3_ef_r, s3_ef_nxt;
  logic [CHAN_W-1:0] s3_ep_r, s3_ep_nxt;
  logic [CHAN_W-1:0] s3_eq_r, s3_eq_nxt;
  logic [CHAN_W-1:0] s3_et_r, s3_et_nxt;
  logic [NF_W+M_W-1:0]  pf;
  logic [NP_W+M_W-1:0]  pp;
  logic [NQT_W+M_W-1:0] pq, pt;
  sector_t           s3_sec_r;
  logic              s3_sz_r;

  // stage 4: estimate times divisor
  logic              s4_v_r;
  logic [NF_W-1:0]   s4_nf_r, s4_mf_r, s4_mf_nxt;
  logic [NP_W-1:0]   s4_np_r, s4_mp_r, s4_mp_nxt;
  logic [NQT_W-1:0]  s4_nq_r, s4_mq_r, s4_mq_nxt;
  logic [NQT_W-1:0]  s4_nt_r, s4_mt_r, s4_mt_nxt;
  logic [CHAN_W-1:0] s4_ef_r, s4_ep_r, s4_eq_r, s4_et_r;
  sector_t           s4_sec_r;
  logic              s4_sz_r;

  // stage 5: corrected channels, sector select
  logic              s5_v_r;
  logic [CHAN_W-1:0] s5_red_r, s5_red_nxt;
  logic [CHAN_W-1:0] s5_grn_r, s5_grn_nxt;
  logic [CHAN_W-1:0] s5_blu_r, s5_blu_nxt;
  logic [CHAN_W-1:0] c_full, c_p, c_q, c_t;

  // stage 6: gamma fractions
  logic              s6_v_r;
  logic [ROM_W-1:0]  s6_fr_r, s6_fg_r, s6_fb_r;

  // stage 7: output register
  logic              out_v_r;
  out_item_t         out_r, out_nxt;
  logic [PROD_W-1:0] dr, dg, db;

  assign en        = !out_v_r || !out_stall;
  assign pop       = en && !stat.empty;
  assign out_valid = out_v_r;
  assign out_data  = out_r;

  always_comb begin
    s1_v255_nxt = (V255_W'(pop_data.val) << CHAN_W) - V255_W'(pop_data.val);
    s1_ds_nxt   = SAT_W'(PCT_MAX) - pop_data.sat;
    s1_srq_nxt  = SR_W'(pop_data.sat) * SR_W'(pop_data.rem);
    s1_srt_nxt  = SR_W'(pop_data.sat) * SR_W'(REM_W'(HUE_SECTOR_DEG) - pop_data.rem);

    s2_nf_nxt = NF_W'(s1_v255_r);
    s2_np_nxt = NP_W'(s1_v255_r) * NP_W'(s1_ds_r);
    s2_nq_nxt = NQT_W'(s1_v255_r) * NQT_W'(SR_W'(QT_SCALE) - s1_srq_r);
    s2_nt_nxt = NQT_W'(s1_v255_r) * NQT_W'(SR_W'(QT_SCALE) - s1_srt_r);

    pf = (NF_W+M_W)'(s2_nf_r) * (NF_W+M_W)'(M_FULL);
    pp = (NP_W+M_W)'(s2_np_r) * (NP_W+M_W)'(M_P);
    pq = (NQT_W+M_W)'(s2_nq_r) * (NQT_W+M_W)'(M_QT);
    pt = (NQT_W+M_W)'(s2_nt_r) * (NQT_W+M_W)'(M_QT);
    s3_ef_nxt = pf[K_FULL+CHAN_W-1:K_FULL];
    s3_ep_nxt = pp[K_P+CHAN_W-1:K_P];
    s3_eq_nxt = pq[K_QT+CHAN_W-1:K_QT];
    s3_et_nxt = pt[K_QT+CHAN_W-1:K_QT];

    s4_mf_nxt = NF_W'(s3_ef_r) * NF_W'(D_FULL);
    s4_mp_nxt = NP_W'(s3_ep_r) * NP_W'(D_P);
    s4_mq_nxt = NQT_W'(s3_eq_r) * NQT_W'(D_QT);
    s4_mt_nxt = NQT_W'(s3_et_r) * NQT_W'(D_QT);

    // estimate is at most one low
    c_full = s4_ef_r + CHAN_W'((s4_nf_r - s4_mf_r) >= NF_W'(D_FULL));
    c_p    = s4_ep_r + CHAN_W'((s4_np_r - s4_mp_r) >= NP_W'(D_P));
    c_q    = s4_eq_r + CHAN_W'((s4_nq_r - s4_mq_r) >= NQT_W'(D_QT));
    c_t    = s4_et_r + CHAN_W'((s4_nt_r - s4_mt_r) >= NQT_W'(D_QT));

    case (s4_sec_r)
      SEC_R_TO_Y: begin
        s5_red_nxt = c_full; s5_grn_nxt = c_t;    s5_blu_nxt = c_p;
      end
      SEC_Y_TO_G: begin
        s5_red_nxt = c_q;    s5_grn_nxt = c_full; s5_blu_nxt = c_p;
      end
      SEC_G_TO_C: begin
        s5_red_nxt = c_p;    s5_grn_nxt = c_full; s5_blu_nxt = c_t;
      end
      SEC_C_TO_B: begin
        s5_red_nxt = c_p;    s5_grn_nxt = c_q;    s5_blu_nxt = c_full;
      end
      SEC_B_TO_M: begin
        s5_red_nxt = c_t;    s5_grn_nxt = c_p;    s5_blu_nxt = c_full;
      end
      SEC_M_TO_R: begin
        s5_red_nxt = c_full; s5_grn_nxt = c_p;    s5_blu_nxt = c_q;
      end
      default: begin
        s5_red_nxt = c_full; s5_grn_nxt = c_p;    s5_blu_nxt = c_q;
      end
    endcase
    // gray: all channels at full
    if (s4_sz_r) begin
      s5_red_nxt = c_full;
      s5_grn_nxt = c_full;
      s5_blu_nxt = c_full;
    end

    dr = PROD_W'(s6_fr_r) * PROD_W'(scale);
    dg = PROD_W'(s6_fg_r) * PROD_W'(scale);
    db = PROD_W'(s6_fb_r) * PROD_W'(scale);
    out_nxt.red_duty   = dr[GAMMA_FRAC_BITS+DUTY_W-1:GAMMA_FRAC_BITS];
    out_nxt.green_duty = dg[GAMMA_FRAC_BITS+DUTY_W-1:GAMMA_FRAC_BITS];
    out_nxt.blue_duty  = db[GAMMA_FRAC_BITS+DUTY_W-1:GAMMA_FRAC_BITS];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r  <= 1'b0;
      s2_v_r  <= 1'b0;
      s3_v_r  <= 1'b0;
      s4_v_r  <= 1'b0;
      s5_v_r  <= 1'b0;
      s6_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else if (en) begin
      s1_v_r  <= pop;
      s2_v_r  <= s1_v_r;
      s3_v_r  <= s2_v_r;
      s4_v_r  <= s3_v_r;
      s5_v_r  <= s4_v_r;
      s6_v_r  <= s5_v_r;
      out_v_r <= s6_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_v255_r <= s1_v255_nxt;
      s1_ds_r   <= s1_ds_nxt;
      s1_srq_r  <= s1_srq_nxt;
      s1_srt_r  <= s1_srt_nxt;
      s1_sec_r  <= pop_data.sector;
      s1_sz_r   <= pop_data.sat_zero;

      s2_nf_r  <= s2_nf_nxt;
      s2_np_r  <= s2_np_nxt;
      s2_nq_r  <= s2_nq_nxt;
      s2_nt_r  <= s2_nt_nxt;
      s2_sec_r <= s1_sec_r;
      s2_sz_r  <= s1_sz_r;

      s3_nf_r  <= s2_nf_r;
      s3_np_r  <= s2_np_r;
      s3_nq_r  <= s2_nq_r;
      s3_nt_r  <= s2_nt_r;
      s3_ef_r  <= s3_ef_nxt;
      s3_ep_r  <= s3_ep_nxt;
      s3_eq_r  <= s3_eq_nxt;
      s3_et_r  <= s3_et_nxt;
      s3_sec_r <= s2_sec_r;
      s3_sz_r  <= s2_sz_r;

      s4_nf_r  <= s3_nf_r;
      s4_np_r  <= s3_np_r;
      s4_nq_r  <= s3_nq_r;
      s4_nt_r  <= s3_nt_r;
      s4_mf_r  <= s4_mf_nxt;
      s4_mp_r  <= s4_mp_nxt;
      s4_mq_r  <= s4_mq_nxt;
      s4_mt_r  <= s4_mt_nxt;
      s4_ef_r  <= s3_ef_r;
      s4_ep_r  <= s3_ep_r;
      s4_eq_r  <= s3_eq_r;
      s4_et_r  <= s3_et_r;
      s4_sec_r <= s3_sec_r;
      s4_sz_r  <= s3_sz_r;

      s5_red_r <= s5_red_nxt;
      s5_grn_r <= s5_grn_nxt;
      s5_blu_r <= s5_blu_nxt;

      s6_fr_r <= GAMMA_RG[s5_red_r];
      s6_fg_r <= GAMMA_RG[s5_grn_r];
      s6_fb_r <= GAMMA_B[s5_blu_r];

      out_r <= out_nxt;
    end
  end

endmodule

// ===== hdl/hsv_to_rgb_gamma_pwm.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hsv_to_rgb_gamma_pwm
// path: front hold register, then the queue, then the back pipeline to the output register
// throughput: one color per cycle while out_stall is low, set by the fully pipelined back end
// the queue holds four colors, so input keeps flowing through short out stalls
// reset: synchronous active-low rst_n clears all valid state and the queue,
// and sets pwm_bits to 8; no clearing pass, the gamma tables are constant
// ----------------------------------------------------------------------------
module hsv_to_rgb_gamma_pwm import hsv_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  in_item_t              in_data,
  output logic                  out_valid,
  input  logic                  out_stall,
  output out_item_t             out_data,
  input  logic                  cfg_wr_en,
  input  logic [PWM_BITS_W-1:0] cfg_wr_data
);

  // full-scale duty kept instead of the raw bit count
  logic [MAX_PWM_BITS-1:0] scale_r;
  logic [MAX_PWM_BITS-1:0] scale_nxt;
  logic [PWM_BITS_W-1:0]   bits_clamped;

  // front to queue
  logic       push;
  hsv_cls_t   push_data;
  // queue to back
  logic       pop;
  hsv_cls_t   pop_data;
  fifo_stat_t stat;

  // zero bits means one bit, anything past the maximum saturates
  always_comb begin
    bits_clamped = cfg_wr_data;
    if (cfg_wr_data == '0) begin
      bits_clamped = PWM_BITS_W'(1);
    end else if (cfg_wr_data > PWM_BITS_W'(MAX_PWM_BITS)) begin
      bits_clamped = PWM_BITS_W'(MAX_PWM_BITS);
    end
    scale_nxt = MAX_PWM_BITS'(((MAX_PWM_BITS+1)'(1) << bits_clamped) - 1'b1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scale_r <= MAX_PWM_BITS'((1 << PWM_BITS_RESET) - 1);
    end else if (cfg_wr_en) begin
      scale_r <= scale_nxt;
    end
  end

  // front: takes a transaction, clamps and classifies by hue sector
  hsv_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .stat      (stat),
    .push      (push),
    .push_data (push_data)
  );

  // queue decouples the two halves
  hsv_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .pop_data  (pop_data),
    .stat      (stat)
  );

  // back: rgb channels, gamma lookup, duty scaling into the output register
  hsv_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .stat      (stat),
    .pop       (pop),
    .pop_data  (pop_data),
    .scale     (scale_r),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

// ===== hdl/hsv_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hsv_checker
// port-level checks on the converter, bound to the top level
// ----------------------------------------------------------------------------
module hsv_checker import hsv_pkg::*; (
  input logic      clk,
  input logic      rst_n,
  input logic      in_valid,
  input logic      in_stall,
  input logic      out_valid,
  input logic      out_stall,
  input out_item_t out_data
);

  logic [4:0] pending_r;
  logic [4:0] pending_nxt;
  logic       in_acc;
  logic       out_acc;

  assign in_acc  = in_valid && !in_stall;
  assign out_acc = out_valid && !out_stall;

  always_comb begin
    pending_nxt = pending_r + 5'(in_acc) - 5'(out_acc);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pending_r <= '0;
    end else begin
      pending_r <= pending_nxt;
    end
  end

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  // no result without an accepted color behind it
  a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> pending_r != '0)
    else $error("result without pending transaction");

  // input only stalls once the holding stage and queue are both full
  a_stall_backlog: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> pending_r >= 5'(FIFO_DEPTH + 1))
    else $error("input stalled with room in the queue");

  // reset empties the output
  a_reset_clear: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind hsv_to_rgb_gamma_pwm hsv_checker u_checker (.*);

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench for hsv_to_rgb_gamma_pwm
// drives colors through the valid/stall input channel and checks every duty
// triple against an in-bench predictor with its own exact gamma curves; covers
// the reset resolution, sector edges, hue wrap, clamped fields and the pwm
// resolution extremes, then long random runs with idle bursts on both sides
// ----------------------------------------------------------------------------
module testbench import hsv_pkg::*;;

  localparam int CLK_PERIOD   = 10;
  localparam int RESET_CYCLES = 8;
  localparam int RUN_LIMIT    = 400000;  // far above the slowest correct run
  localparam int TAIL_CYCLES  = 20;
  localparam int BIG_W        = 256;     // wide enough for 255^14 << 80

  localparam int RANDOM_ITEMS = 700;
  localparam int BURST_ITEMS  = 100;
  localparam int PHASE_ITEMS  = 100;     // colors between resolution changes

  // dut inputs, all known from time zero
  logic                  clk         = 1'b0;
  logic                  rst_n       = 1'b0;
  logic                  in_valid    = 1'b0;
  logic                  in_stall;
  in_item_t              in_data     = '0;
  logic                  out_valid;
  logic                  out_stall   = 1'b0;
  out_item_t             out_data;
  logic                  cfg_wr_en   = 1'b0;
  logic [PWM_BITS_W-1:0] cfg_wr_data = '0;

  // predictor state: gamma curves and the resolution register as last written
  logic [ROM_W-1:0]      rg_curve [ROM_DEPTH];
  logic [ROM_W-1:0]      b_curve  [ROM_DEPTH];
  logic [PWM_BITS_W-1:0] pwm_bits_model = PWM_BITS_W'(PWM_BITS_RESET);

  out_item_t             pending_duties [$];
  out_item_t             want;
  int                    errors      = 0;
  int                    cycle_count = 0;

  // idle knobs, switched off for the last part of the run
  bit                    gaps_on     = 1'b0;
  bit                    stalls_on   = 1'b0;
  int                    stall_run   = 0;

  hsv_to_rgb_gamma_pwm uut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_data     (in_data),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_data    (out_data),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

  initial begin
    forever #(CLK_PERIOD / 2) clk = ~clk;
  end

  // watchdog: a hung handshake ends the run here
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == RUN_LIMIT) begin
      $display("%0t: timeout with %0d duty triples pending", $time, pending_duties.size());
      $display("Verification failed");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // predictor
  // ---------------------------------------------------------------------------

  // floor(2^frac_bits * (x/255)^(num/den)), built bit by bit from the top:
  // keep a bit when y^den * 255^num still fits under x^num * 2^(den*frac_bits)
  function automatic logic [ROM_W-1:0] curve_point(input int unsigned x,
                                                   input int unsigned num,
                                                   input int unsigned den);
    logic [BIG_W-1:0] bound;
    logic [BIG_W-1:0] trial;
    logic [BIG_W-1:0] yw;
    logic [ROM_W-1:0] y;
    bound = BIG_W'(1);
    for (int k = 0; k < num; k++) bound = bound * BIG_W'(x);
    bound = bound << (den * GAMMA_FRAC_BITS);
    y = '0;
    for (int bit_pos = ROM_W - 1; bit_pos >= 0; bit_pos--) begin
      yw = BIG_W'(y | (ROM_W'(1) << bit_pos));
      trial = BIG_W'(1);
      for (int k = 0; k < den; k++) trial = trial * yw;
      for (int k = 0; k < num; k++) trial = trial * BIG_W'(255);
      if (trial <= bound) y[bit_pos] = 1'b1;
    end
    return y;
  endfunction

  // duty = (curve fraction * full scale) >> frac bits, truncated to 16 bits
  function automatic logic [DUTY_W-1:0] scaled_duty(input logic [ROM_W-1:0] frac,
                                                    input logic [DUTY_W-1:0] scale);
    logic [ROM_W+DUTY_W-1:0] prod;
    prod = frac * scale;
    return prod[GAMMA_FRAC_BITS +: DUTY_W];
  endfunction

  function automatic out_item_t predict_duty(input in_item_t c);
    int unsigned       h, s, v, rem, full_ch, p, q, t;
    int unsigned       r, g, b, bits;
    sector_t           sec;
    logic [DUTY_W-1:0] scale;
    out_item_t         d;
    h = 32'(c.hue);
    s = 32'(c.saturation);
    v = 32'(c.brightness);
    // hue wraps once, percentages clamp at 100
    if (h >= 360) h = h - 360;
    if (s > 100) s = 100;
    if (v > 100) v = 100;
    full_ch = 255 * v / 100;
    rem     = h % 60;
    p       = 255 * v * (100 - s) / 10000;
    q       = 255 * v * (6000 - s * rem) / 600000;
    t       = 255 * v * (6000 - s * (60 - rem)) / 600000;
    sec     = sector_t'(3'(h / 60));
    if (s == 0) begin
      r = full_ch;
      g = full_ch;
      b = full_ch;
    end else begin
      case (sec)
        SEC_R_TO_Y: begin r = full_ch; g = t;       b = p;       end
        SEC_Y_TO_G: begin r = q;       g = full_ch; b = p;       end
        SEC_G_TO_C: begin r = p;       g = full_ch; b = t;       end
        SEC_C_TO_B: begin r = p;       g = q;       b = full_ch; end
        SEC_B_TO_M: begin r = t;       g = p;       b = full_ch; end
        default: begin    r = full_ch; g = p;       b = q;       end
      endcase
    end
    // zero resolution acts as one bit, anything past the max clamps
    bits = 32'(pwm_bits_model);
    if (bits < 1) bits = 1;
    if (bits > MAX_PWM_BITS) bits = MAX_PWM_BITS;
    scale = DUTY_W'((32'd1 << bits) - 1);
    d.red_duty   = scaled_duty(rg_curve[r & 8'hFF], scale);
    d.green_duty = scaled_duty(rg_curve[g & 8'hFF], scale);
    d.blue_duty  = scaled_duty(b_curve[b & 8'hFF], scale);
    return d;
  endfunction

  // ---------------------------------------------------------------------------
  // result side: random stall bursts and the duty checker
  // ---------------------------------------------------------------------------

  always @(posedge clk) begin
    if (stall_run > 0) begin
      out_stall <= 1'b1;
      stall_run <= stall_run - 1;
    end else if (stalls_on && $urandom_range(0, 7) == 0) begin
      out_stall <= 1'b1;
      stall_run <= $urandom_range(0, 14);  // random burst length
    end else begin
      out_stall <= 1'b0;
    end
  end

  task automatic check_duty(input string chan, input logic [DUTY_W-1:0] exp_duty,
                            input logic [DUTY_W-1:0] act_duty);
    if (exp_duty !== act_duty) begin
      $display("%0t: %s duty mismatch, expected %0d actual %0d",
               $time, chan, exp_duty, act_duty);
      errors++;
    end
  endtask

  // every accepted result transaction is matched against the oldest prediction
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (pending_duties.size() == 0) begin
        $display("%0t: result with no color pending, expected none actual %h",
                 $time, out_data);
        errors++;
      end else begin
        want = pending_duties.pop_front();
        check_duty("red", want.red_duty, out_data.red_duty);
        check_duty("green", want.green_duty, out_data.green_duty);
        check_duty("blue", want.blue_duty, out_data.blue_duty);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // input side
  // ---------------------------------------------------------------------------

  // called at a clock edge; valid is touched once per edge so that a valid
  // left high after the previous transaction is simply reused
  task automatic send_color(input in_item_t c);
    if (gaps_on && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= c;
    do @(posedge clk); while (in_stall);
    pending_duties.push_back(predict_duty(c));
  endtask

  task automatic send_hsv(input int unsigned h, input int unsigned s, input int unsigned v);
    in_item_t c;
    c.hue        = HUE_W'(h);
    c.saturation = SAT_W'(s);
    c.brightness = VAL_W'(v);
    send_color(c);
  endtask

  // drop valid and wait until every predicted triple has come back
  task automatic drain_block();
    in_valid <= 1'b0;
    while (pending_duties.size() != 0) @(posedge clk);
  endtask

  // only called with the block drained
  task automatic set_pwm_bits(input logic [PWM_BITS_W-1:0] bits);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= bits;
    @(posedge clk);
    cfg_wr_en      <= 1'b0;
    pwm_bits_model  = bits;
  endtask

  function automatic logic [PWM_BITS_W-1:0] pick_pwm_bits();
    case ($urandom_range(0, 7))
      0: return PWM_BITS_W'(0);
      1: return PWM_BITS_W'(1);
      2: return PWM_BITS_W'(MAX_PWM_BITS);
      3: return PWM_BITS_W'(MAX_PWM_BITS + 1);
      4: return '1;
      default: return PWM_BITS_W'($urandom_range(0, 31));
    endcase
  endfunction

  function automatic in_item_t random_color();
    in_item_t c;
    case ($urandom_range(0, 9))
      0: begin  // any bit pattern, out of range fields included
        c.hue        = HUE_W'($urandom_range(0, 511));
        c.saturation = SAT_W'($urandom_range(0, 127));
        c.brightness = VAL_W'($urandom_range(0, 127));
      end
      1: begin  // gray
        c.hue        = HUE_W'($urandom_range(0, 360));
        c.saturation = '0;
        c.brightness = VAL_W'($urandom_range(0, 100));
      end
      2: begin  // around sector edges, saturation often full and never zero
        c.hue        = HUE_W'(60 * $urandom_range(0, 6) - $urandom_range(0, 1));
        c.saturation = SAT_W'($urandom_range(0, 1) ? 100 : $urandom_range(1, 100));
        c.brightness = VAL_W'($urandom_range(0, 1) ? 100 : $urandom_range(0, 100));
      end
      default: begin
        c.hue        = HUE_W'($urandom_range(0, 360));
        c.saturation = SAT_W'($urandom_range(0, 100));
        c.brightness = VAL_W'($urandom_range(0, 100));
      end
    endcase
    return c;
  endfunction

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  // runs on the reset resolution of 8 bits
  task automatic test_color_corners();
    send_hsv(0, 100, 100);     // pure red
    send_hsv(60, 100, 100);    // sector boundaries
    send_hsv(120, 100, 100);
    send_hsv(180, 100, 100);
    send_hsv(240, 100, 100);
    send_hsv(300, 100, 100);
    send_hsv(359, 100, 100);
    send_hsv(360, 100, 100);   // wraps to red
    send_hsv(511, 127, 127);   // hue past the wrap, both percentages clamped
    send_hsv(200, 0, 100);     // gray at full value, channel 255 everywhere
    send_hsv(0, 0, 0);         // black
    send_hsv(45, 100, 0);
    send_hsv(90, 37, 63);
    send_hsv(150, 1, 100);
    send_hsv(270, 99, 1);
    send_hsv(330, 127, 100);
    drain_block();
  endtask

  task automatic test_pwm_extremes();
    logic [PWM_BITS_W-1:0] settings [5] = '{PWM_BITS_W'(0), PWM_BITS_W'(1),
                                            PWM_BITS_W'(MAX_PWM_BITS),
                                            PWM_BITS_W'(MAX_PWM_BITS + 1),
                                            PWM_BITS_W'(31)};
    foreach (settings[i]) begin
      set_pwm_bits(settings[i]);
      send_hsv(0, 0, 100);     // white reaches full scale
      send_hsv(210, 60, 70);
      drain_block();
    end
  endtask

  task automatic test_random_colors();
    gaps_on   = 1'b1;
    stalls_on = 1'b1;
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n % PHASE_ITEMS == 0) begin
        drain_block();
        set_pwm_bits(pick_pwm_bits());
      end else if ($urandom_range(0, 59) == 0) begin
        drain_block();         // sender holds off until the pipe is empty
      end
      send_color(random_color());
    end
    drain_block();
  endtask

  // last part: no idle cycles on either side
  task automatic test_back_to_back();
    gaps_on   = 1'b0;
    stalls_on = 1'b0;
    while (stall_run > 0 || out_stall) @(posedge clk);
    set_pwm_bits(pick_pwm_bits());
    for (int n = 0; n < BURST_ITEMS; n++) send_color(random_color());
    drain_block();
  endtask

  initial begin
    for (int x = 0; x < ROM_DEPTH; x++) begin
      rg_curve[x] = curve_point(x, 14, 5);   // exponent 2.8
      b_curve[x]  = curve_point(x, 7, 2);    // exponent 3.5
    end
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_color_corners();
    test_pwm_extremes();
    test_random_colors();
    test_back_to_back();

    repeat (TAIL_CYCLES) @(posedge clk);
    if (errors == 0 && pending_duties.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
hdl/hsv_pkg.sv
hdl/hsv_front.sv
hdl/hsv_fifo.sv
hdl/hsv_back.sv
hdl/hsv_to_rgb_gamma_pwm.sv
hdl/hsv_checker.sv
tb/testbench.sv
